### hw/rtl/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, switched off while reset is high
`define CHK_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// clocked assertion that also holds across reset
`define CHK_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hw/rtl/pkcs1chk_pkg.sv
// types, constants and the digest prefix table of the signature padding checker
package pkcs1chk_pkg;

  // default sizes, handed down from the top level
  localparam int DEF_MAX_BLOCK_BYTES = 1024;
  localparam int DEF_MAX_HASH_BYTES  = 64;

  // field widths
  localparam int LEN_W      = 11;
  localparam int HLEN_W     = 7;
  localparam int HIDX_IN_W  = 6;
  localparam int COUNT_W    = 10;
  localparam int STATUS_W   = 2;
  localparam int CFG_IDX_W  = 2;

  localparam int MIN_BLOCK_BYTES = 16;
  localparam logic [COUNT_W-1:0] COUNT_MAX = 10'd1023;

  // sha-1 digest info layout
  localparam int SHA1_PREFIX_LEN = 15;
  localparam int SHA1_DIGEST_LEN = 20;
  localparam int SHA1_PAYLOAD    = SHA1_PREFIX_LEN + SHA1_DIGEST_LEN;

  // largest payload length that can come with a good or mismatch status
  localparam int GOOD_LENGTH_MAX = (1 << HLEN_W) - 1;

  // queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // block byte values
  localparam logic [7:0] HDR_BYTE0 = 8'h00;
  localparam logic [7:0] HDR_BYTE1 = 8'h01;
  localparam logic [7:0] PAD_BYTE  = 8'hFF;
  localparam logic [7:0] SEP_BYTE  = 8'h00;

  // result codes
  localparam logic [STATUS_W-1:0] STATUS_GOOD     = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_BAD_PAD  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_MISMATCH = 2'd2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BLOCK_LENGTH = 2'd0,
    REG_HASH_KIND    = 2'd1,
    REG_HASH_LENGTH  = 2'd2
  } cfg_reg_t;

  typedef enum logic {
    OP_LOAD_HASH  = 1'b0,
    OP_BLOCK_BYTE = 1'b1
  } opcode_t;

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_PAD     = 2'd1,
    PH_PAYLOAD = 2'd2
  } phase_t;

  typedef struct packed {
    logic [LEN_W-1:0]  block_length;
    logic              hash_kind;
    logic [HLEN_W-1:0] hash_length;
  } cfg_t;

  typedef struct packed {
    opcode_t              op;
    logic [7:0]           data;
    logic [HIDX_IN_W-1:0] hash_index;
  } item_t;

  // sha-1 digest info prefix, one byte per position
  function automatic logic [7:0] digest_info_byte(input logic [3:0] k);
    logic [7:0] b;
    unique case (k)
      4'd0:    b = 8'h30;
      4'd1:    b = 8'h21;
      4'd2:    b = 8'h30;
      4'd3:    b = 8'h09;
      4'd4:    b = 8'h06;
      4'd5:    b = 8'h05;
      4'd6:    b = 8'h2B;
      4'd7:    b = 8'h0E;
      4'd8:    b = 8'h03;
      4'd9:    b = 8'h02;
      4'd10:   b = 8'h1A;
      4'd11:   b = 8'h05;
      4'd12:   b = 8'h00;
      4'd13:   b = 8'h04;
      4'd14:   b = 8'h14;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

### hw/rtl/pkcs1chk_front.sv
// front end: takes input beats, drops out-of-range hash loads, feeds the queue
module pkcs1chk_front import pkcs1chk_pkg::*; #(
  parameter int MAX_HASH_BYTES = DEF_MAX_HASH_BYTES
) (
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 opcode,
  input  logic [7:0]           data_byte,
  input  logic [HIDX_IN_W-1:0] hash_index,
  input  logic                 q_full,
  output logic                 q_push,
  output item_t                q_item
);

  logic keep;

  // block bytes always pass, hash loads only when they land inside the store
  always_comb begin
    q_item.op         = opcode_t'(opcode);
    q_item.data       = data_byte;
    q_item.hash_index = hash_index;
    keep     = (q_item.op == OP_BLOCK_BYTE) || (int'(hash_index) < MAX_HASH_BYTES);
    in_stall = q_full;
    q_push   = in_valid && !q_full && keep;
  end

endmodule

### hw/rtl/pkcs1chk_fifo.sv
// short queue of classified items between front and back
module pkcs1chk_fifo import pkcs1chk_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  item_t push_item,
  output logic  full,
  input  logic  pop,
  output logic  empty,
  output item_t head
);

  item_t             slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   fill;

  assign full  = (fill == (QPTR_W+1)'(QUEUE_DEPTH));
  assign empty = (fill == '0);
  assign head  = slots[rd_ptr];

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      unique case ({push, pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_item;
  end

endmodule

### hw/rtl/pkcs1chk_back.sv
// back end: hash store, padding parser, digest compare and result register
module pkcs1chk_back import pkcs1chk_pkg::*; #(
  parameter int MAX_BLOCK_BYTES = DEF_MAX_BLOCK_BYTES,
  parameter int MAX_HASH_BYTES  = DEF_MAX_HASH_BYTES
) (
  input  logic                clk,
  input  logic                rst,
  input  cfg_t                cfg,
  input  logic                q_empty,
  input  item_t               q_head,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [STATUS_W-1:0] status,
  output logic [COUNT_W-1:0]  payload_length
);

  localparam int POS_W  = $clog2(MAX_BLOCK_BYTES);
  localparam int CMP_W  = (POS_W + 1 > LEN_W) ? POS_W + 1 : LEN_W;
  localparam int HIDX_W = $clog2(MAX_HASH_BYTES);

  // parser state
  logic [POS_W-1:0]   byte_position, byte_position_next;
  phase_t             phase, phase_next;
  logic               padding_bad, padding_bad_next;
  logic [COUNT_W-1:0] payload_count, payload_count_next;

  logic [7:0] hash_store [MAX_HASH_BYTES];

  // compare stage
  logic               s2_valid;
  logic               s2_last;
  logic [7:0]         s2_data;
  logic               s2_cmp;
  logic               s2_early_mis;
  logic               s2_good;
  logic [COUNT_W-1:0] s2_plen;
  logic [7:0]         rd_data;
  logic               mis_acc;

  // parser wires
  logic               back_en;
  logic               blk;
  logic               len_bad;
  logic [CMP_W-1:0]   bl_ext;
  logic [CMP_W-1:0]   leff;
  logic               last;
  logic               pb_upd;
  phase_t             phase_upd;
  logic [COUNT_W-1:0] count_upd;
  logic [COUNT_W-1:0] need;
  logic               good;
  logic               cmp;
  logic               pre_mis;
  logic               force_mis;
  logic [HIDX_W-1:0]  rd_addr;
  logic [7:0]         data;

  // compare wires
  logic byte_mis;
  logic mis_total;

  // the whole back end holds while a finished result waits
  assign back_en = !(out_valid && out_stall);
  assign q_pop   = back_en && !q_empty;
  assign blk     = q_pop && (q_head.op == OP_BLOCK_BYTE);
  assign data    = q_head.data;

  // block length check and last-byte detection
  always_comb begin
    bl_ext  = CMP_W'(cfg.block_length);
    len_bad = (bl_ext < CMP_W'(MIN_BLOCK_BYTES)) || (bl_ext > CMP_W'(MAX_BLOCK_BYTES));
    if (bl_ext < CMP_W'(MIN_BLOCK_BYTES)) begin
      leff = CMP_W'(MIN_BLOCK_BYTES);
    end else if (bl_ext > CMP_W'(MAX_BLOCK_BYTES)) begin
      leff = CMP_W'(MAX_BLOCK_BYTES);
    end else begin
      leff = bl_ext;
    end
    last = (CMP_W'(byte_position) + 1'b1) >= leff;
    need = cfg.hash_kind ? COUNT_W'(SHA1_PAYLOAD) : COUNT_W'(cfg.hash_length);
  end

  // padding parser, next state
  always_comb begin
    pb_upd    = padding_bad;
    phase_upd = phase;
    count_upd = payload_count;
    cmp       = 1'b0;
    pre_mis   = 1'b0;
    force_mis = 1'b0;
    rd_addr   = '0;
    if (!padding_bad) begin
      unique case (phase)
        PH_HEADER: begin
          if (byte_position == '0) begin
            if (data != HDR_BYTE0) pb_upd = 1'b1;
          end else begin
            if (data != HDR_BYTE1) pb_upd = 1'b1;
            phase_upd = PH_PAD;
          end
          if (last) pb_upd = 1'b1;
        end
        PH_PAD: begin
          if (data == SEP_BYTE && !last) begin
            phase_upd = PH_PAYLOAD;
            count_upd = '0;
          end else if (data != PAD_BYTE || last) begin
            pb_upd = 1'b1;
          end
        end
        PH_PAYLOAD: begin
          // prefix bytes against the table, digest bytes against the store
          if (cfg.hash_kind) begin
            if (payload_count < COUNT_W'(SHA1_PREFIX_LEN)) begin
              pre_mis = (data != digest_info_byte(payload_count[3:0]));
            end else if (payload_count < COUNT_W'(SHA1_PAYLOAD)) begin
              cmp     = 1'b1;
              rd_addr = HIDX_W'(payload_count - COUNT_W'(SHA1_PREFIX_LEN));
            end
          end else if (payload_count < COUNT_W'(cfg.hash_length)) begin
            if (payload_count >= COUNT_W'(MAX_HASH_BYTES)) begin
              force_mis = 1'b1;
            end else begin
              cmp     = 1'b1;
              rd_addr = HIDX_W'(payload_count);
            end
          end
          if (payload_count < COUNT_MAX) count_upd = payload_count + 1'b1;
        end
        default: phase_upd = phase;
      endcase
    end

    good = !len_bad && !pb_upd && (phase_upd == PH_PAYLOAD) && (count_upd == need);

    byte_position_next = byte_position;
    phase_next         = phase;
    padding_bad_next   = padding_bad;
    payload_count_next = payload_count;
    if (blk) begin
      if (last) begin
        byte_position_next = '0;
        phase_next         = PH_HEADER;
        padding_bad_next   = 1'b0;
        payload_count_next = '0;
      end else begin
        byte_position_next = byte_position + 1'b1;
        phase_next         = phase_upd;
        padding_bad_next   = pb_upd;
        payload_count_next = count_upd;
      end
    end
  end

  // parser state register
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
      phase         <= PH_HEADER;
      padding_bad   <= 1'b0;
      payload_count <= '0;
    end else begin
      byte_position <= byte_position_next;
      phase         <= phase_next;
      padding_bad   <= padding_bad_next;
      payload_count <= payload_count_next;
    end
  end

  // hash store: loads write, digest bytes read into the compare stage
  always_ff @(posedge clk) begin
    if (q_pop && q_head.op == OP_LOAD_HASH) begin
      hash_store[HIDX_W'(q_head.hash_index)] <= q_head.data;
    end
    if (blk && cmp) begin
      rd_data <= hash_store[rd_addr];
    end
  end

  // compare stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (back_en) begin
      s2_valid <= blk;
    end
  end

  always_ff @(posedge clk) begin
    if (back_en) begin
      s2_last      <= last;
      s2_data      <= data;
      s2_cmp       <= cmp;
      s2_early_mis <= pre_mis || force_mis;
      s2_good      <= good;
      s2_plen      <= count_upd;
    end
  end

  // digest compare and mismatch accumulation
  assign byte_mis  = s2_early_mis || (s2_cmp && (s2_data != rd_data));
  assign mis_total = mis_acc || byte_mis;

  always_ff @(posedge clk) begin
    if (rst) begin
      mis_acc   <= 1'b0;
      out_valid <= 1'b0;
    end else if (back_en) begin
      out_valid <= s2_valid && s2_last;
      if (s2_valid) mis_acc <= s2_last ? 1'b0 : mis_total;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (back_en && s2_valid && s2_last) begin
      if (s2_good) begin
        status         <= mis_total ? STATUS_MISMATCH : STATUS_GOOD;
        payload_length <= s2_plen;
      end else begin
        status         <= STATUS_BAD_PAD;
        payload_length <= '0;
      end
    end
  end

endmodule

### hw/rtl/pkcs1_v15_signature_checker.sv
// Signature padding checker top level: configuration registers, front, queue and back.
// Takes one beat per clock unless in_stall is high: hash loads (opcode 0) fill the
// expected digest store and block bytes (opcode 1) stream the exponentiated signature
// block, and exactly one registered result beat (status and payload_length) comes out
// per block. The sustained rate is one item per cycle while out_stall is low, set by
// the parser and the one read port of the hash store; a result held by out_stall
// pauses the back end, and in_stall rises once the four-entry queue in front of it is
// full. A hash load issued mid-block affects only the block bytes that follow it. The
// hash store is not cleared by reset: comparing against an entry never loaded gives an
// undefined verdict. The user must write configuration only while no block is in
// progress and the pipeline has drained; the block itself does not enforce this.
module pkcs1_v15_signature_checker import pkcs1chk_pkg::*; #(
  parameter int MAX_BLOCK_BYTES = DEF_MAX_BLOCK_BYTES,
  parameter int MAX_HASH_BYTES  = DEF_MAX_HASH_BYTES
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [LEN_W-1:0]     cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 opcode,
  input  logic [7:0]           data_byte,
  input  logic [HIDX_IN_W-1:0] hash_index,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [STATUS_W-1:0]  status,
  output logic [COUNT_W-1:0]   payload_length
);

  cfg_t  cfg;
  logic  q_full;
  logic  q_push;
  item_t q_item;
  logic  q_empty;
  logic  q_pop;
  item_t q_head;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.block_length <= LEN_W'(128);
      cfg.hash_kind    <= 1'b1;
      cfg.hash_length  <= HLEN_W'(20);
    end else if (cfg_write) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_BLOCK_LENGTH: cfg.block_length <= cfg_data;
        REG_HASH_KIND:    cfg.hash_kind    <= cfg_data[0];
        REG_HASH_LENGTH:  cfg.hash_length  <= cfg_data[HLEN_W-1:0];
        default:          cfg              <= cfg;
      endcase
    end
  end

  // intake and classification
  pkcs1chk_front #(
    .MAX_HASH_BYTES (MAX_HASH_BYTES)
  ) u_front (
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .opcode     (opcode),
    .data_byte  (data_byte),
    .hash_index (hash_index),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_item     (q_item)
  );

  // decoupling queue
  pkcs1chk_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (q_item),
    .full      (q_full),
    .pop       (q_pop),
    .empty     (q_empty),
    .head      (q_head)
  );

  // parser, compare and result
  pkcs1chk_back #(
    .MAX_BLOCK_BYTES (MAX_BLOCK_BYTES),
    .MAX_HASH_BYTES  (MAX_HASH_BYTES)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .q_empty        (q_empty),
    .q_head         (q_head),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .status         (status),
    .payload_length (payload_length)
  );

endmodule

### hw/rtl/pkcs1chk_sva.sv
// port-level checker for the signature padding checker, bound to the top level
`include "assert_macros.svh"

module pkcs1chk_sva import pkcs1chk_pkg::*; (
  input logic                clk,
  input logic                rst,
  input logic                out_valid,
  input logic                out_stall,
  input logic [STATUS_W-1:0] status,
  input logic [COUNT_W-1:0]  payload_length
);

  // no result beat straight after reset
  `CHK_ASSERT_ALWAYS(a_reset_quiet, clk, rst |=> !out_valid, "result beat right after reset")

  // status carries one of the three defined codes
  `CHK_ASSERT(a_status_code, clk, rst, out_valid |-> (status == STATUS_GOOD || status == STATUS_BAD_PAD || status == STATUS_MISMATCH), "undefined status code")

  // a padding failure reports no payload
  `CHK_ASSERT(a_bad_no_length, clk, rst, (out_valid && status == STATUS_BAD_PAD) |-> (payload_length == '0), "payload length on bad padding")

  // a parsed payload is never longer than the largest digest length
  `CHK_ASSERT(a_good_length, clk, rst, (out_valid && status != STATUS_BAD_PAD) |-> (payload_length <= COUNT_W'(GOOD_LENGTH_MAX)), "payload length out of range")

  // a stalled result beat holds
  `CHK_ASSERT(a_out_hold, clk, rst, (out_valid && out_stall) |=> (out_valid && $stable(status) && $stable(payload_length)), "stalled result beat changed")

endmodule

bind pkcs1_v15_signature_checker pkcs1chk_sva u_pkcs1chk_sva (.*);

### tb/testbench.sv
// self-checking testbench of the signature padding checker: directed and random blocks
`timescale 1ns / 100ps

module testbench;
  import pkcs1chk_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int MAX_BLOCK   = DEF_MAX_BLOCK_BYTES;
  localparam int MAX_HASH    = DEF_MAX_HASH_BYTES;
  localparam logic [8*SHA1_PREFIX_LEN-1:0] SHA1_DIGEST_INFO =
    120'h3021300906052B0E03021A05000414;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  plen;
  } verdict_t;

  typedef enum int {
    SHAPE_GOOD, SHAPE_BAD_DIGEST, SHAPE_BAD_HEADER, SHAPE_BAD_PAD,
    SHAPE_NO_SEP, SHAPE_SEP_LAST, SHAPE_SHORT, SHAPE_LONG, SHAPE_NOISE
  } shape_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_BLOCK_LENGTH;
  logic [LEN_W-1:0]     cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic                 opcode = OP_LOAD_HASH;
  logic [7:0]           data_byte = '0;
  logic [HIDX_IN_W-1:0] hash_index = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [STATUS_W-1:0]  status;
  logic [COUNT_W-1:0]   payload_length;

  // predictor copy of registers and block state
  logic [LEN_W-1:0]  cfg_len = 11'd128;
  logic              cfg_sha1 = 1'b1;
  logic [HLEN_W-1:0] cfg_hash_len = 7'd20;
  int unsigned       blk_pos = 0;
  phase_t            blk_phase = PH_HEADER;
  bit                pad_bad = 1'b0;
  bit                digest_bad = 1'b0;
  int unsigned       payload_seen = 0;
  logic [7:0]        digest_store [MAX_HASH];

  verdict_t    verdict_q [$];
  logic [7:0]  block_bytes [$];
  int unsigned items_sent = 0;
  int unsigned verdicts_made = 0;
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;
  int          hold_request = 0;
  bit          idle_on = 1'b1;

  pkcs1_v15_signature_checker dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .opcode         (opcode),
    .data_byte      (data_byte),
    .hash_index     (hash_index),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .status         (status),
    .payload_length (payload_length)
  );

  always #5 clk = ~clk;

  // run-away guard
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic int unsigned beat_gap();
    return idle_on ? $urandom_range(0, 6) : 0;
  endfunction

  function automatic int unsigned usable_length(input logic [LEN_W-1:0] bl);
    if (bl < MIN_BLOCK_BYTES) return MIN_BLOCK_BYTES;
    if (bl > MAX_BLOCK) return MAX_BLOCK;
    return bl;
  endfunction

  function automatic logic [7:0] prefix_byte(input int unsigned k);
    return SHA1_DIGEST_INFO[8*(SHA1_PREFIX_LEN-1-k) +: 8];
  endfunction

  // compare one payload byte against prefix or stored digest
  function automatic void digest_byte_seen(input logic [7:0] b);
    int unsigned k;
    k = payload_seen;
    if (cfg_sha1) begin
      if (k < SHA1_PREFIX_LEN) begin
        if (b != prefix_byte(k)) digest_bad = 1'b1;
      end else if (k < SHA1_PAYLOAD) begin
        if (k - SHA1_PREFIX_LEN >= MAX_HASH || b != digest_store[k - SHA1_PREFIX_LEN])
          digest_bad = 1'b1;
      end
    end else if (k < cfg_hash_len) begin
      if (k >= MAX_HASH || b != digest_store[k]) digest_bad = 1'b1;
    end
    if (payload_seen < COUNT_MAX) payload_seen++;
  endfunction

  // padding parser; queues a verdict at the last byte of a block
  function automatic void block_byte_taken(input logic [7:0] b);
    int unsigned eff, need;
    bit len_bad, at_end;
    verdict_t v;
    len_bad = cfg_len < MIN_BLOCK_BYTES || cfg_len > MAX_BLOCK;
    eff = usable_length(cfg_len);
    at_end = blk_pos + 1 >= eff;
    if (!pad_bad) begin
      case (blk_phase)
        PH_HEADER: begin
          if (blk_pos == 0) begin
            if (b != HDR_BYTE0) pad_bad = 1'b1;
          end else begin
            if (b != HDR_BYTE1) pad_bad = 1'b1;
            blk_phase = PH_PAD;
          end
          if (at_end) pad_bad = 1'b1;
        end
        PH_PAD: begin
          if (b == SEP_BYTE && !at_end) begin
            blk_phase = PH_PAYLOAD;
            payload_seen = 0;
          end else if (b != PAD_BYTE || at_end) begin
            pad_bad = 1'b1;
          end
        end
        default: digest_byte_seen(b);
      endcase
    end
    if (!at_end) begin
      blk_pos++;
      return;
    end
    v.status = STATUS_BAD_PAD;
    v.plen = '0;
    if (!len_bad && !pad_bad && blk_phase == PH_PAYLOAD) begin
      need = cfg_sha1 ? SHA1_PAYLOAD : cfg_hash_len;
      if (payload_seen == need) begin
        v.status = digest_bad ? STATUS_MISMATCH : STATUS_GOOD;
        v.plen = COUNT_W'(payload_seen);
      end
    end
    verdict_q.push_back(v);
    verdicts_made++;
    blk_pos = 0;
    blk_phase = PH_HEADER;
    pad_bad = 1'b0;
    digest_bad = 1'b0;
    payload_seen = 0;
  endfunction

  // offer one beat, wait for it to be taken, then update the predictor
  task automatic send_item(input opcode_t op, input logic [7:0] d,
                           input logic [HIDX_IN_W-1:0] idx);
    int unsigned gap;
    gap = beat_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    opcode <= op;
    data_byte <= d;
    hash_index <= idx;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
    if (op == OP_LOAD_HASH) digest_store[idx] = d;
    else block_byte_taken(d);
  endtask

  // stop offering and wait until every verdict is back and the pipe is empty
  task automatic wait_for_verdicts();
    in_valid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_config(input logic [LEN_W-1:0] bl, input logic hk,
                              input logic [HLEN_W-1:0] hl);
    cfg_write <= 1'b1;
    cfg_index <= REG_BLOCK_LENGTH;
    cfg_data <= bl;
    @(posedge clk);
    cfg_index <= REG_HASH_KIND;
    cfg_data <= LEN_W'(hk);
    @(posedge clk);
    cfg_index <= REG_HASH_LENGTH;
    cfg_data <= LEN_W'(hl);
    @(posedge clk);
    cfg_write <= 1'b0;
    cfg_len = bl;
    cfg_sha1 = hk;
    cfg_hash_len = hl;
  endtask

  function automatic logic [7:0] expected_payload_byte(input int unsigned k);
    if (cfg_sha1) begin
      if (k < SHA1_PREFIX_LEN) return prefix_byte(k);
      if (k < SHA1_PAYLOAD) return digest_store[k - SHA1_PREFIX_LEN];
    end else if (k < cfg_hash_len && k < MAX_HASH) begin
      return digest_store[k];
    end
    return 8'($urandom_range(0, 255));
  endfunction

  // lay out one block of the current length, then spoil it as the shape says
  function automatic void build_block(input shape_t shape);
    int unsigned eff, plen, npad, k;
    eff = usable_length(cfg_len);
    plen = cfg_sha1 ? SHA1_PAYLOAD : cfg_hash_len;
    if (shape == SHAPE_SHORT && plen > 0) plen--;
    if (shape == SHAPE_LONG) plen++;
    if (plen > eff - 3) plen = eff - 3;
    npad = eff - 3 - plen;
    block_bytes.delete();
    block_bytes.push_back(HDR_BYTE0);
    block_bytes.push_back(HDR_BYTE1);
    repeat (npad) block_bytes.push_back(PAD_BYTE);
    block_bytes.push_back(SEP_BYTE);
    for (k = 0; k < plen; k++) block_bytes.push_back(expected_payload_byte(k));
    case (shape)
      SHAPE_BAD_DIGEST: begin
        if (plen > 0) begin
          k = 3 + npad + $urandom_range(0, plen - 1);
          block_bytes[k] = block_bytes[k] ^ 8'($urandom_range(1, 255));
        end
      end
      SHAPE_BAD_HEADER: begin
        k = $urandom_range(0, 1);
        block_bytes[k] = block_bytes[k] ^ 8'($urandom_range(1, 255));
      end
      SHAPE_BAD_PAD: begin
        if (npad > 0) block_bytes[2 + $urandom_range(0, npad - 1)] = 8'($urandom_range(1, 254));
      end
      SHAPE_NO_SEP: for (k = 2; k < eff; k++) block_bytes[k] = PAD_BYTE;
      SHAPE_SEP_LAST: begin
        for (k = 2; k < eff - 1; k++) block_bytes[k] = PAD_BYTE;
        block_bytes[eff - 1] = SEP_BYTE;
      end
      SHAPE_NOISE: for (k = 0; k < eff; k++) block_bytes[k] = 8'($urandom_range(0, 255));
      default: ;
    endcase
  endfunction

  // stream one block, with hash loads slipped in at the given percentage
  task automatic send_block(input shape_t shape, input int unsigned load_pct);
    int unsigned i;
    build_block(shape);
    for (i = 0; i < block_bytes.size(); i++) begin
      if ($urandom_range(0, 99) < load_pct)
        send_item(OP_LOAD_HASH, 8'($urandom_range(0, 255)), 6'($urandom_range(0, 63)));
      send_item(OP_BLOCK_BYTE, block_bytes[i], 6'($urandom_range(0, 63)));
    end
  endtask

  // result sink: random stalls per beat, long hold-off on request
  initial begin : verdict_sink
    int stall_left;
    stall_left = 0;
    forever begin
      if (hold_request > 0) begin
        stall_left = hold_request;
        hold_request = 0;
      end
      out_stall <= (stall_left > 0);
      @(posedge clk);
      if (stall_left > 0) stall_left--;
      else if (out_valid) stall_left = beat_gap();
    end
  end

  // compare each result beat with the oldest predicted verdict
  always @(posedge clk) begin : verdict_check
    verdict_t want;
    if (!rst && out_valid && !out_stall) begin
      if (verdict_q.size() == 0) begin
        error_count++;
        if (error_count <= 10)
          $display("unexpected result beat: status %0d length %0d", status, payload_length);
      end else begin
        want = verdict_q.pop_front();
        if (status !== want.status || payload_length !== want.plen) begin
          error_count++;
          if (error_count <= 10)
            $display("result mismatch: expected status %0d length %0d, got status %0d length %0d",
                     want.status, want.plen, status, payload_length);
        end
      end
    end
  end

  // reset values of the registers, with every store entry loaded first
  task automatic test_reset_defaults();
    int unsigned i;
    for (i = 0; i < MAX_HASH; i++) begin
      if (i == 0) send_item(OP_LOAD_HASH, 8'h00, 6'(i));
      else if (i == 1) send_item(OP_LOAD_HASH, 8'hFF, 6'(i));
      else send_item(OP_LOAD_HASH, 8'($urandom_range(0, 255)), 6'(i));
    end
    send_block(SHAPE_GOOD, 0);
    wait_for_verdicts();
  endtask

  // header, padding, separator and short-payload faults on the shortest block
  task automatic test_padding_faults();
    write_config(11'd16, 1'b0, 7'd0);
    send_block(SHAPE_GOOD, 0);
    send_block(SHAPE_BAD_HEADER, 0);
    send_block(SHAPE_BAD_PAD, 0);
    send_block(SHAPE_NO_SEP, 0);
    send_block(SHAPE_SEP_LAST, 0);
    wait_for_verdicts();
    write_config(11'd16, 1'b0, 7'd13);
    send_block(SHAPE_SHORT, 0);
    wait_for_verdicts();
  endtask

  // sha-1 digest info checks at the tightest block
  task automatic test_sha1_digest();
    write_config(11'd38, 1'b1, 7'd20);
    send_block(SHAPE_GOOD, 0);
    send_block(SHAPE_BAD_DIGEST, 0);
    send_block(SHAPE_SHORT, 0);
    wait_for_verdicts();
  endtask

  // raw digests up to the store size and beyond it
  task automatic test_raw_lengths();
    write_config(11'd67, 1'b0, 7'd64);
    send_block(SHAPE_GOOD, 0);
    wait_for_verdicts();
    write_config(11'd73, 1'b0, 7'd70);
    send_block(SHAPE_GOOD, 0);
    wait_for_verdicts();
  endtask

  // block lengths below the legal range are clamped and always rejected
  task automatic test_length_out_of_range();
    write_config(11'd0, 1'b0, 7'd0);
    send_block(SHAPE_GOOD, 0);
    wait_for_verdicts();
    write_config(11'd15, 1'b0, 7'd0);
    send_block(SHAPE_GOOD, 0);
    wait_for_verdicts();
  endtask

  // hash loads interleaved with block bytes
  task automatic test_midblock_loads();
    write_config(11'd38, 1'b1, 7'd20);
    send_block(SHAPE_GOOD, 25);
    wait_for_verdicts();
  endtask

  // long result hold-off so the queue fills and the input stalls
  task automatic test_backpressure();
    write_config(11'd16, 1'b0, 7'd4);
    idle_on = 1'b0;
    hold_request = 400;
    repeat (5) send_block(SHAPE_GOOD, 0);
    wait_for_verdicts();
    idle_on = 1'b1;
  endtask

  // random settings, mostly well-formed blocks with random content
  task automatic test_random_traffic();
    int unsigned start_items, start_verdicts, eff, hl_cap, nblk, pick;
    logic [LEN_W-1:0] bl;
    logic [HLEN_W-1:0] hl;
    shape_t shape;
    start_items = items_sent;
    start_verdicts = verdicts_made;
    while (items_sent - start_items < 100 || verdicts_made - start_verdicts < 6) begin
      pick = $urandom_range(0, 99);
      if (pick < 8) bl = LEN_W'($urandom_range(0, 15));
      else if (pick < 13) bl = LEN_W'($urandom_range(100, 160));
      else bl = LEN_W'($urandom_range(16, 48));
      eff = usable_length(bl);
      hl_cap = (eff - 3 < MAX_HASH) ? eff - 3 : MAX_HASH;
      if ($urandom_range(0, 9) == 0) hl = HLEN_W'($urandom_range(0, 127));
      else hl = HLEN_W'($urandom_range(0, hl_cap));
      wait_for_verdicts();
      write_config(bl, 1'($urandom_range(0, 1)), hl);
      idle_on = ($urandom_range(0, 3) != 0);
      nblk = (eff > 100) ? 1 : $urandom_range(2, 5);
      repeat (nblk) begin
        pick = $urandom_range(0, 99);
        if (pick < 55) shape = SHAPE_GOOD;
        else if (pick < 70) shape = SHAPE_BAD_DIGEST;
        else if (pick < 75) shape = SHAPE_BAD_HEADER;
        else if (pick < 80) shape = SHAPE_BAD_PAD;
        else if (pick < 84) shape = SHAPE_NO_SEP;
        else if (pick < 88) shape = SHAPE_SEP_LAST;
        else if (pick < 92) shape = SHAPE_SHORT;
        else if (pick < 96) shape = SHAPE_LONG;
        else shape = SHAPE_NOISE;
        if ($urandom_range(0, 3) == 0)
          repeat ($urandom_range(1, 4))
            send_item(OP_LOAD_HASH, 8'($urandom_range(0, 255)), 6'($urandom_range(0, 63)));
        send_block(shape, ($urandom_range(0, 4) == 0) ? 5 : 0);
      end
    end
    idle_on = 1'b1;
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    test_reset_defaults();
    test_padding_faults();
    test_sha1_digest();
    test_raw_lengths();
    test_length_out_of_range();
    test_midblock_loads();
    test_backpressure();
    test_random_traffic();
    wait_for_verdicts();
    repeat (20) @(posedge clk);
    if (error_count == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule

### files.f
+incdir+hw/rtl
hw/rtl/pkcs1chk_pkg.sv
hw/rtl/pkcs1chk_front.sv
hw/rtl/pkcs1chk_fifo.sv
hw/rtl/pkcs1chk_back.sv
hw/rtl/pkcs1_v15_signature_checker.sv
hw/rtl/pkcs1chk_sva.sv
tb/testbench.sv
